[rtl/cfr_pkg.sv]
package cfr_pkg;

    // framing characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // frame header "RBN"
    localparam logic [7:0] HDR_0 = 8'h52;
    localparam logic [7:0] HDR_1 = 8'h42;
    localparam logic [7:0] HDR_2 = 8'h4E;

    // field offsets from the header start, contiguous from the buttons on
    localparam logic [4:0] OFS_BUTTON  = 5'd9;
    localparam int unsigned OFS_STICK   = 11;
    localparam int unsigned OFS_TRIGGER = 15;

    // field byte indexes counted from the first button byte
    localparam logic [2:0] FLD_BTN_LO = 3'd0;
    localparam logic [2:0] FLD_BTN_HI = 3'd1;
    localparam logic [2:0] FLD_STK_0  = 3'(OFS_STICK - 9);
    localparam logic [2:0] FLD_STK_1  = 3'(OFS_STICK - 8);
    localparam logic [2:0] FLD_STK_2  = 3'(OFS_STICK - 7);
    localparam logic [2:0] FLD_STK_3  = 3'(OFS_STICK - 6);
    localparam logic [2:0] FLD_TRG_0  = 3'(OFS_TRIGGER - 9);
    localparam logic [2:0] FLD_TRG_1  = 3'(OFS_TRIGGER - 8);
    localparam logic [3:0] FIELD_BYTES = 4'd8;

    localparam logic [8:0] STICK_MID = 9'd128;

    // silence supervision
    localparam logic [7:0] LIMIT_RESET = 8'd5;
    localparam logic [7:0] COUNT_RESET = 8'd255;

    typedef struct packed {
        logic tick;
        logic byte_seen;
    } t_link_ctrl;

endpackage

[rtl/controller_frame_receiver_core.sv]
// channel  | handshake                  | words carried
// ---------+----------------------------+------------------------------------------
// input    | i_in_valid / o_in_ready    | i_func, i_rx_byte
// output   | o_out_valid / i_out_ready  | o_frame_decoded, o_buttons, o_stick_0..3,
//          |                            | o_trigger_0..1, o_link_ok
// config   | i_cfg_we                   | i_cfg_wdata (silence limit)
//
// one word at a time
// a frame end runs the header search through the single ring read port, one byte a cycle
// reset starts a clearing pass that zeroes the ring;
// o_in_ready stays low until it is over, config writes are still taken
// a result waiting in the output register holds off only the final load of the next word
module controller_frame_receiver_core #(
    parameter int RING_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_frame_decoded,
    output logic [15:0]       o_buttons,
    output logic signed [8:0] o_stick_0,
    output logic signed [8:0] o_stick_1,
    output logic signed [8:0] o_stick_2,
    output logic signed [8:0] o_stick_3,
    output logic [7:0]        o_trigger_0,
    output logic [7:0]        o_trigger_1,
    output logic              o_link_ok,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);

    localparam int AW         = $clog2(RING_DEPTH);
    localparam int SCAN_READS = RING_DEPTH + 2;
    localparam int CW         = $clog2(RING_DEPTH + 3);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CRCHK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIELD = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // ring address arithmetic, modulo the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [4:0] k);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(k);
        if (s >= (AW+1)'(RING_DEPTH)) begin
            s = s - (AW+1)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(RING_DEPTH - 1) : a - 1'b1;
    endfunction

    // ring memory, one write and one registered read a cycle
    logic [7:0]    mem [RING_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // control state
    logic [2:0]    r_state,   n_state;
    logic [AW-1:0] r_pos,     n_pos;      // next write slot
    logic [AW-1:0] r_base,    n_base;     // slot of the byte that ended the frame
    logic [AW-1:0] r_addr,    n_addr;     // read / clear address
    logic [AW-1:0] r_rd_addr;             // address of the word in r_rd_data
    logic          r_rd_vld;
    logic [CW-1:0] r_cnt,     n_cnt;      // reads issued
    logic [CW-1:0] r_got,     n_got;      // reads returned
    logic [3:0]    r_icnt,    n_icnt;     // field reads issued
    logic [2:0]    r_fcnt,    n_fcnt;     // field reads returned
    logic          r_is_lf,   n_is_lf;
    logic          r_decoded, n_decoded;
    logic [7:0]    r_w1, r_w2;            // the two bytes above the one just read

    // latched controller fields
    logic [15:0]   r_buttons, n_buttons;
    logic [7:0]    r_stick [4];
    logic [7:0]    n_stick [4];
    logic [7:0]    r_trig  [2];
    logic [7:0]    n_trig  [2];

    // output register
    logic          r_out_valid, n_out_valid;
    logic          r_out_dec;
    logic [15:0]   r_out_btn;
    logic [8:0]    r_out_stk [4];
    logic [7:0]    r_out_trg [2];
    logic          r_out_link;

    logic                issue;
    logic                hit;
    logic                in_acc;
    logic                out_free;
    logic                link_ok;
    cfr_pkg::t_link_ctrl link_ctrl;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // compare unit: header test on the returning scan byte
    assign hit = (r_state == S_SCAN) && r_rd_vld && (r_got >= CW'(2))
              && (r_rd_data == cfr_pkg::HDR_0) && (r_w1 == cfr_pkg::HDR_1)
              && (r_w2 == cfr_pkg::HDR_2);

    assign issue = ((r_state == S_SCAN) && (r_cnt < CW'(SCAN_READS)) && !hit)
                || ((r_state == S_FIELD) && (r_icnt < cfr_pkg::FIELD_BYTES));

    assign link_ctrl.tick      = in_acc && i_func;
    assign link_ctrl.byte_seen = in_acc && !i_func;

    cfr_link_timer u_link_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (link_ctrl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_link_ok   (link_ok)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_base      = r_base;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_got       = r_got;
        n_icnt      = r_icnt;
        n_fcnt      = r_fcnt;
        n_is_lf     = r_is_lf;
        n_decoded   = r_decoded;
        n_buttons   = r_buttons;
        n_stick     = r_stick;
        n_trig      = r_trig;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = i_rx_byte;
        mem_raddr   = r_addr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = 8'd0;
                n_addr    = ring_add(r_addr, 5'd1);
                if (r_addr == AW'(RING_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_decoded = 1'b0;
                    if (i_func) begin
                        n_state = S_DONE;
                    end else begin
                        // store the byte and fetch the one before it
                        mem_we    = 1'b1;
                        mem_raddr = ring_dec(r_pos);
                        n_is_lf   = (i_rx_byte == cfr_pkg::CHAR_LF);
                        n_base    = r_pos;
                        n_pos     = ring_add(r_pos, 5'd1);
                        n_state   = S_CRCHK;
                    end
                end
            end
            S_CRCHK: begin
                if (r_is_lf && (r_rd_data == cfr_pkg::CHAR_CR)) begin
                    // scan from two above the frame end downwards
                    n_addr  = ring_add(r_base, 5'd2);
                    n_cnt   = '0;
                    n_got   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_addr = ring_dec(r_addr);
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_rd_vld) begin
                    n_got = r_got + 1'b1;
                end
                if (hit) begin
                    n_addr  = ring_add(r_rd_addr, cfr_pkg::OFS_BUTTON);
                    n_icnt  = '0;
                    n_fcnt  = '0;
                    n_state = S_FIELD;
                end else if (r_rd_vld && (r_got == CW'(SCAN_READS - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_FIELD: begin
                if (issue) begin
                    n_addr = ring_add(r_addr, 5'd1);
                    n_icnt = r_icnt + 4'd1;
                end
                if (r_rd_vld) begin
                    n_fcnt = r_fcnt + 3'd1;
                    case (r_fcnt)
                        cfr_pkg::FLD_BTN_LO: n_buttons[7:0]  = r_rd_data;
                        cfr_pkg::FLD_BTN_HI: n_buttons[15:8] = r_rd_data;
                        cfr_pkg::FLD_STK_0:  n_stick[0]      = r_rd_data;
                        cfr_pkg::FLD_STK_1:  n_stick[1]      = r_rd_data;
                        cfr_pkg::FLD_STK_2:  n_stick[2]      = r_rd_data;
                        cfr_pkg::FLD_STK_3:  n_stick[3]      = r_rd_data;
                        cfr_pkg::FLD_TRG_0:  n_trig[0]       = r_rd_data;
                        cfr_pkg::FLD_TRG_1:  n_trig[1]       = r_rd_data;
                        default: n_buttons = r_buttons;
                    endcase
                    if (r_fcnt == cfr_pkg::FLD_TRG_1) begin
                        n_decoded = 1'b1;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_buttons   <= '0;
            r_stick     <= '{default: 8'd0};
            r_trig      <= '{default: 8'd0};
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_addr      <= n_addr;
            r_rd_vld    <= issue;
            r_out_valid <= n_out_valid;
            r_buttons   <= n_buttons;
            r_stick     <= n_stick;
            r_trig      <= n_trig;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_cnt     <= n_cnt;
        r_got     <= n_got;
        r_icnt    <= n_icnt;
        r_fcnt    <= n_fcnt;
        r_is_lf   <= n_is_lf;
        r_decoded <= n_decoded;
        r_rd_addr <= mem_raddr;
        if (r_state == S_CRCHK) begin
            r_w1 <= 8'd0;
            r_w2 <= 8'd0;
        end else if (r_rd_vld) begin
            r_w1 <= r_rd_data;
            r_w2 <= r_w1;
        end
        // load the result word, sticks re-centred on the way out
        if ((r_state == S_DONE) && out_free) begin
            r_out_dec    <= r_decoded;
            r_out_btn    <= r_buttons;
            r_out_stk[0] <= {1'b0, r_stick[0]} - cfr_pkg::STICK_MID;
            r_out_stk[1] <= cfr_pkg::STICK_MID - {1'b0, r_stick[1]};
            r_out_stk[2] <= {1'b0, r_stick[2]} - cfr_pkg::STICK_MID;
            r_out_stk[3] <= cfr_pkg::STICK_MID - {1'b0, r_stick[3]};
            r_out_trg[0] <= r_trig[0];
            r_out_trg[1] <= r_trig[1];
            r_out_link   <= link_ok;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_frame_decoded = r_out_dec;
    assign o_buttons       = r_out_btn;
    assign o_stick_0       = $signed(r_out_stk[0]);
    assign o_stick_1       = $signed(r_out_stk[1]);
    assign o_stick_2       = $signed(r_out_stk[2]);
    assign o_stick_3       = $signed(r_out_stk[3]);
    assign o_trigger_0     = r_out_trg[0];
    assign o_trigger_1     = r_out_trg[1];
    assign o_link_ok       = r_out_link;

endmodule

[rtl/cfr_link_timer.sv]
module cfr_link_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfr_pkg::t_link_ctrl i_ctrl,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    output logic                o_link_ok
);

    logic [7:0] r_limit;
    logic [7:0] r_count;
    logic       r_link;
    logic [7:0] n_count;
    logic       n_link;

    always_comb begin
        n_count = r_count;
        n_link  = r_link;
        if (i_ctrl.byte_seen) begin
            n_count = 8'd0;
        end else if (i_ctrl.tick) begin
            // compare against the limit, count only while below it
            if (r_count >= r_limit) begin
                n_link = 1'b0;
            end else begin
                n_link  = 1'b1;
                n_count = r_count + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cfr_pkg::LIMIT_RESET;
            r_count <= cfr_pkg::COUNT_RESET;
            r_link  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_link  <= n_link;
        end
    end

    assign o_link_ok = r_link;

endmodule

[rtl/cfr_checker.sv]
module cfr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_frame_decoded,
    input logic [15:0]       o_buttons,
    input logic signed [8:0] o_stick_0,
    input logic signed [8:0] o_stick_1,
    input logic signed [8:0] o_stick_2,
    input logic signed [8:0] o_stick_3,
    input logic [7:0]        o_trigger_0,
    input logic [7:0]        o_trigger_1,
    input logic              o_link_ok
);

    // reset starts the clearing pass: nothing taken, nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or result right after reset");

    // one word in flight: ready drops after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after an accepted word");

    // a new result only appears at the end of a word's processing
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no word in work");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_buttons)
            && $stable(o_frame_decoded) && $stable(o_link_ok)
            && $stable(o_stick_0) && $stable(o_stick_1) && $stable(o_stick_2)
            && $stable(o_stick_3) && $stable(o_trigger_0) && $stable(o_trigger_1))
        else $error("stalled result changed");

endmodule

bind controller_frame_receiver_core cfr_checker u_cfr_checker (.*);

[tb/sv/controller_frame_receiver_core_tb.sv]
module controller_frame_receiver_core_tb;

    localparam int RING = 256;
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam int PHASES = 5;
    localparam int WORDS_PER_PHASE = 300;
    // longest frame end: full header search plus field loads
    localparam int SETTLE_CYCLES = RING + 20;
    // clearing pass plus every word at its slowest, several times over
    localparam longint TIMEOUT_UNITS = 10_000_000;

    typedef struct packed {
        logic       func;
        logic [7:0] rx;
    } t_word;

    typedef struct packed {
        logic            decoded;
        logic [15:0]     buttons;
        logic [3:0][8:0] stick;
        logic [1:0][7:0] trig;
        logic            link;
    } t_status;

    // how a frame sent by the stimulus is spoilt, if at all
    typedef enum logic [1:0] {
        FRAME_OK,
        FRAME_BAD_HDR,
        FRAME_SHORT,
        FRAME_NO_LF
    } t_frame_kind;

    // clock, reset and ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_func = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    wire in_ready;
    wire out_valid;
    wire frame_decoded;
    wire [15:0] buttons;
    wire signed [8:0] stick_0, stick_1, stick_2, stick_3;
    wire [7:0] trigger_0, trigger_1;
    wire link_ok;

    // mirror of the receiver state
    logic [7:0]      ring_copy [RING];
    logic [7:0]      wr_ptr = 8'd0;
    logic [7:0]      quiet_ticks = cfr_pkg::COUNT_RESET;
    logic [7:0]      quiet_limit = cfr_pkg::LIMIT_RESET;
    logic            link_good = 1'b0;
    logic [15:0]     btn_state = 16'h0000;
    logic [3:0][7:0] stick_state = '0;
    logic [1:0][7:0] trig_state = '0;

    // words waiting to go in, results still owed by the block
    t_word   words_to_send [$];
    t_status status_due [$];

    t_word   cur_word;
    t_status predicted;
    t_status want, got;
    bit      holding = 1'b0;
    int      in_gap = 0;
    int      out_stall = 0;
    int      calm_left = 0;
    logic [7:0] phase_limit [PHASES];

    int words_queued = 0;
    int words_sent = 0;
    int ticks_sent = 0;
    int frames_hit = 0;
    int lost_seen = 0;
    int results_seen = 0;
    int fail_count = 0;

    controller_frame_receiver_core #(
        .RING_DEPTH(RING)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (in_func),
        .i_rx_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_decoded(frame_decoded),
        .o_buttons      (buttons),
        .o_stick_0      (stick_0),
        .o_stick_1      (stick_1),
        .o_stick_2      (stick_2),
        .o_stick_3      (stick_3),
        .o_trigger_0    (trigger_0),
        .o_trigger_1    (trigger_1),
        .o_link_ok      (link_ok),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // works out the status word the block owes for one input word
    function automatic t_status predict_status(input t_word w);
        t_status    s;
        logic [7:0] p;
        logic       found;
        int         i, k;
        s = '0;
        if (w.func == FUNC_BYTE) begin
            ring_copy[wr_ptr] = w.rx;
            quiet_ticks = 8'd0;
            p = wr_ptr - 8'd1;
            // frame end: lf with cr just before it, stale bytes included
            if (w.rx == cfr_pkg::CHAR_LF && ring_copy[p] == cfr_pkg::CHAR_CR) begin
                found = 1'b0;
                // newest header first, starting at the lf itself
                for (i = 0; i < RING && !found; i++) begin
                    p = wr_ptr - 8'(i);
                    if (ring_copy[p] == cfr_pkg::HDR_0
                            && ring_copy[8'(p + 1)] == cfr_pkg::HDR_1
                            && ring_copy[8'(p + 2)] == cfr_pkg::HDR_2) begin
                        found = 1'b1;
                        // field offsets wrap round the ring end
                        btn_state = {ring_copy[8'(p + cfr_pkg::OFS_BUTTON + 1)],
                                     ring_copy[8'(p + cfr_pkg::OFS_BUTTON)]};
                        for (k = 0; k < 4; k++)
                            stick_state[k] = ring_copy[8'(p + cfr_pkg::OFS_STICK + k)];
                        for (k = 0; k < 2; k++)
                            trig_state[k] = ring_copy[8'(p + cfr_pkg::OFS_TRIGGER + k)];
                    end
                end
                s.decoded = found;
            end
            wr_ptr = wr_ptr + 8'd1;
        end else if (quiet_ticks >= quiet_limit) begin
            link_good = 1'b0;
        end else begin
            link_good = 1'b1;
            quiet_ticks = quiet_ticks + 8'd1;
        end
        s.buttons = btn_state;
        // even sticks raw - mid, odd sticks mid - raw
        for (k = 0; k < 4; k++)
            s.stick[k] = k[0] ? (cfr_pkg::STICK_MID - {1'b0, stick_state[k]})
                              : ({1'b0, stick_state[k]} - cfr_pkg::STICK_MID);
        s.trig = trig_state;
        s.link = link_good;
        return s;
    endfunction

    // mostly short gaps, a few long ones, none during a calm stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0 || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_word(input logic func, input logic [7:0] b);
        t_word w;
        w.func = func;
        w.rx = b;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    // header, six filler bytes, eight field bytes, cr lf
    task automatic push_frame(input t_frame_kind kind, input logic [63:0] fields);
        logic [7:0] seq [19];
        int n, i, bad;
        seq[0] = cfr_pkg::HDR_0;
        seq[1] = cfr_pkg::HDR_1;
        seq[2] = cfr_pkg::HDR_2;
        for (i = 3; i < cfr_pkg::OFS_BUTTON; i++)
            seq[i] = 8'($urandom);
        for (i = 0; i < 8; i++)
            seq[cfr_pkg::OFS_BUTTON + i] = fields[8*i +: 8];
        seq[17] = cfr_pkg::CHAR_CR;
        seq[18] = cfr_pkg::CHAR_LF;
        n = 19;
        case (kind)
            FRAME_BAD_HDR: begin
                bad = $urandom_range(0, 2);
                seq[bad] = seq[bad] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_SHORT: begin
                // frame end lands in the filler or the fields, so stale bytes can get latched
                n = $urandom_range(4, 16);
                seq[n] = cfr_pkg::CHAR_CR;
                seq[n + 1] = cfr_pkg::CHAR_LF;
                n = n + 2;
            end
            FRAME_NO_LF: begin
                seq[18] = 8'($urandom);
                if (seq[18] == cfr_pkg::CHAR_LF)
                    seq[18] = seq[18] ^ 8'h01;
            end
            default: ;
        endcase
        for (i = 0; i < n; i++) begin
            // ticks inside a frame leave the ring alone
            if (kind == FRAME_OK && $urandom_range(0, 15) == 0)
                push_word(FUNC_TICK, 8'($urandom));
            push_word(FUNC_BYTE, seq[i]);
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || holding || status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic note_field(input string what, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d: %s expected %h got %h",
                         results_seen, what, want_v, got_v);
        end
    endtask

    // stretches where neither side idles
    always @(posedge clk) begin
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 199) == 0)
            calm_left = $urandom_range(40, 200);
    end

    // input driver: predicts on acceptance, then loads the next word after a gap
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predicted = predict_status(cur_word);
                status_due.push_back(predicted);
                words_sent++;
                if (cur_word.func == FUNC_TICK) begin
                    ticks_sent++;
                    if (!predicted.link)
                        lost_seen++;
                end
                if (predicted.decoded)
                    frames_hit++;
                holding = 1'b0;
                in_gap = pick_gap();
            end
            if (!holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (words_to_send.size() != 0) begin
                    cur_word = words_to_send.pop_front();
                    in_func <= cur_word.func;
                    in_byte <= cur_word.rx;
                    holding = 1'b1;
                end
            end
            // one assignment a step, so valid stays high across back-to-back words
            in_valid <= holding;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got.decoded = frame_decoded;
                got.buttons = buttons;
                got.stick[0] = stick_0;
                got.stick[1] = stick_1;
                got.stick[2] = stick_2;
                got.stick[3] = stick_3;
                got.trig[0] = trigger_0;
                got.trig[1] = trigger_1;
                got.link = link_ok;
                if (status_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing outstanding after %0d results",
                                 results_seen);
                end else begin
                    want = status_due.pop_front();
                    note_field("frame_decoded", want.decoded, got.decoded);
                    note_field("buttons", want.buttons, got.buttons);
                    note_field("stick_0", want.stick[0], got.stick[0]);
                    note_field("stick_1", want.stick[1], got.stick[1]);
                    note_field("stick_2", want.stick[2], got.stick[2]);
                    note_field("stick_3", want.stick[3], got.stick[3]);
                    note_field("trigger_0", want.trig[0], got.trig[0]);
                    note_field("trigger_1", want.trig[1], got.trig[1]);
                    note_field("link_ok", want.link, got.link);
                end
                results_seen++;
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int r, len, j, phase;
        for (j = 0; j < RING; j++)
            ring_copy[j] = 8'h00;
        // reset value first, then limits 1 and 255, then two random limits
        phase_limit[0] = cfr_pkg::LIMIT_RESET;
        phase_limit[1] = 8'd1;
        phase_limit[2] = 8'd255;
        phase_limit[3] = 8'($urandom_range(2, 254));
        phase_limit[4] = 8'($urandom_range(2, 12));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                // limit changes only with the block idle
                wait_drained();
                @(posedge clk);
                cfg_we <= 1'b1;
                cfg_wdata <= phase_limit[phase];
                quiet_limit = phase_limit[phase];
                @(posedge clk);
                cfg_we <= 1'b0;
            end else begin
                push_word(FUNC_TICK, 8'hFF);    // counter still expired from reset
                push_word(FUNC_BYTE, cfr_pkg::CHAR_LF);  // lf after a stale zero, no frame end
                push_word(FUNC_BYTE, cfr_pkg::CHAR_CR);
                push_word(FUNC_BYTE, cfr_pkg::CHAR_LF);  // frame end with no header anywhere
                push_word(FUNC_TICK, 8'h00);    // first tick after a byte
                // field extremes: sticks at 0, 255 and either side of mid
                push_frame(FRAME_OK, {8'h00, 8'hFF, 8'h7F, 8'h80,
                                      8'hFF, 8'h00, 8'hFF, 8'h00});
                push_word(FUNC_BYTE, cfr_pkg::CHAR_CR);
                push_word(FUNC_BYTE, cfr_pkg::CHAR_LF);  // bare frame end finds the old header
            end

            while (words_queued < (phase + 1) * WORDS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    push_frame(FRAME_OK, {32'($urandom), 32'($urandom)});
                end else if (r < 62) begin
                    push_frame(t_frame_kind'($urandom_range(1, 3)),
                               {32'($urandom), 32'($urandom)});
                end else if (r < 77) begin
                    // now and then a run long enough to lose the link
                    if ($urandom_range(0, 4) == 0)
                        len = quiet_limit + $urandom_range(1, 3);
                    else
                        len = $urandom_range(1, 4);
                    repeat (len) push_word(FUNC_TICK, 8'($urandom));
                end else if (r < 90) begin
                    // noise, leaning on the framing characters
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        case ($urandom_range(0, 9))
                            0: push_word(FUNC_BYTE, cfr_pkg::CHAR_CR);
                            1: push_word(FUNC_BYTE, cfr_pkg::CHAR_LF);
                            2: push_word(FUNC_BYTE, cfr_pkg::HDR_0);
                            3: push_word(FUNC_BYTE, cfr_pkg::HDR_1);
                            4: push_word(FUNC_BYTE, cfr_pkg::HDR_2);
                            default: push_word(FUNC_BYTE, 8'($urandom));
                        endcase
                    end
                end else begin
                    push_word(FUNC_BYTE, cfr_pkg::CHAR_CR);
                    push_word(FUNC_BYTE, cfr_pkg::CHAR_LF);
                end
            end
        end

        // everything sent, then let the owed results come home
        while (words_to_send.size() != 0 || holding)
            @(posedge clk);
        for (j = 0; j < 20 * SETTLE_CYCLES && status_due.size() != 0; j++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (status_due.size() != 0) begin
            $display("%0d results never arrived", status_due.size());
            fail_count += status_due.size();
        end

        $display("%0d words sent, %0d of them ticks; %0d frames decoded, %0d link-lost ticks",
                 words_sent, ticks_sent, frames_hit, lost_seen);
        $display("silence limits %0d, %0d, %0d, %0d, %0d; %0d mismatches",
                 phase_limit[0], phase_limit[1], phase_limit[2], phase_limit[3],
                 phase_limit[4], fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("timed out with %0d results still owed", status_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/cfr_pkg.sv
rtl/cfr_link_timer.sv
rtl/controller_frame_receiver_core.sv
rtl/cfr_checker.sv
tb/sv/controller_frame_receiver_core_tb.sv
